@@ rtl/core/mbps_pkg.sv @@
// ---------------------------------------------------------------------------
// mbps_pkg
// Shared types, constants and helpers for the metaball pixel shader core.
// ---------------------------------------------------------------------------
package mbps_pkg;

  // Image and color constants
  localparam int ImageWidth     = 128;
  localparam int ImageHeight    = 128;
  localparam int FalloffEntries = 512;
  localparam logic [23:0] PaperColor = 24'hFFFFFF;

  // Field ramp and ripple constants
  localparam int FieldLo  = 120;
  localparam int FieldHi  = 280;
  localparam int DistShift = 4;
  localparam int RingSpan = 52;
  localparam int RingCap  = 110;
  localparam int RingMin  = 4;

  // Widths
  localparam int CoordW = 7;
  localparam int PosW   = 9;
  localparam int D2W    = 19;   // squared distance, pixel to any center
  localparam int QW     = 9;    // clamped, quantized distance
  localparam int R2W    = 14;   // radius squared
  localparam int NumW   = 22;   // falloff dividend, r2 << 8
  localparam int DenW   = 14;   // falloff divisor
  localparam int QuotW  = 10;   // falloff quotient, always below 1024
  localparam int DivBits   = 2;
  localparam int DivStages = QuotW / DivBits;
  localparam int NumStages = 10;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_BLOB_A_X    = 3'd0,
    REG_BLOB_A_Y    = 3'd1,
    REG_BLOB_B_X    = 3'd2,
    REG_BLOB_B_Y    = 3'd3,
    REG_RADIUS      = 3'd4,
    REG_ACCENT      = 3'd5,
    REG_RING_AMOUNT = 3'd6,
    REG_RING_PHASE  = 3'd7
  } cfg_reg_t;

  // Ripple result traveling alongside the falloff dividers
  typedef struct packed {
    logic       hit;
    logic [7:0] alpha;
  } ring_t;

  // Ripple envelope: ramps up over 12 phase steps, down over the other 51
  typedef logic [63:0][7:0] env_arr_t;

  function automatic env_arr_t build_env();
    env_arr_t e;
    for (int i = 0; i < 64; i++) begin
      if (i < 12) e[i] = 8'((i * 255) / 12);
      else        e[i] = 8'(((63 - i) * 255) / 51);
    end
    return e;
  endfunction

  localparam env_arr_t RingEnv = build_env();

  // Squared distance between an unsigned pixel and a signed center
  function automatic logic [D2W-1:0] sq_dist(input logic [CoordW-1:0] px,
                                             input logic [CoordW-1:0] py,
                                             input logic signed [PosW-1:0] cx,
                                             input logic signed [PosW-1:0] cy);
    logic signed [PosW:0]     dx;
    logic signed [PosW:0]     dy;
    logic signed [2*PosW+1:0] sx;
    logic signed [2*PosW+1:0] sy;
    dx = $signed({3'b000, px}) - {cx[PosW-1], cx};
    dy = $signed({3'b000, py}) - {cy[PosW-1], cy};
    sx = dx * dx;
    sy = dy * dy;
    return D2W'(sx[D2W-2:0]) + D2W'(sy[D2W-2:0]);
  endfunction

  // Blend one channel from paper toward accent by alpha, rounding down
  function automatic logic [7:0] blend(input logic [7:0] p, input logic [7:0] c,
                                       input logic [7:0] a);
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic signed [17:0] step;
    diff = $signed({1'b0, c}) - $signed({1'b0, p});
    prod = 18'(diff) * $signed({10'd0, a});
    step = prod >>> 8;
    return 8'(step) + p;
  endfunction

endpackage

@@ rtl/core/mbps_div.sv @@
// ---------------------------------------------------------------------------
// mbps_div
// Pipelined restoring divider for the falloff term, two quotient bits per
// stage. Stage enables come from the owner's stall chain.
// ---------------------------------------------------------------------------
module mbps_div (
  input  logic                            clk,
  input  logic [mbps_pkg::DivStages-1:0]  en,
  input  logic [mbps_pkg::NumW-1:0]       num,
  input  logic [mbps_pkg::DenW-1:0]       den,
  output logic [mbps_pkg::QuotW-1:0]      quot
);
  import mbps_pkg::*;

  logic [DenW-1:0]  rem_q  [DivStages];
  logic [QuotW-1:0] low_q  [DivStages];
  logic [QuotW-1:0] quo_q  [DivStages];
  logic [DenW-1:0]  den_q  [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [DenW-1:0]  rem_in;
    logic [QuotW-1:0] low_in;
    logic [QuotW-1:0] quo_in;
    logic [DenW-1:0]  den_in;
    logic [DenW-1:0]  rem_next;
    logic [QuotW-1:0] low_next;
    logic [QuotW-1:0] quo_next;

    // Stage input: the operands for the first stage, else the previous stage
    if (s == 0) begin : g_first
      assign rem_in = DenW'(num[NumW-1:QuotW]);
      assign low_in = num[QuotW-1:0];
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
    end

    // Shift in dividend bits, trial subtract per bit
    always_comb begin
      logic [DenW:0] t;
      rem_next = rem_in;
      low_next = low_in;
      quo_next = quo_in;
      for (int b = 0; b < DivBits; b++) begin
        t        = {rem_next, low_next[QuotW-1]};
        low_next = low_next << 1;
        quo_next = quo_next << 1;
        if (t >= {1'b0, den_in}) begin
          t           = t - {1'b0, den_in};
          quo_next[0] = 1'b1;
        end
        rem_next = t[DenW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_q[s] <= rem_next;
        low_q[s] <= low_next;
        quo_q[s] <= quo_next;
        den_q[s] <= den_in;
      end
    end
  end

  assign quot = quo_q[DivStages-1];

endmodule

@@ rtl/core/metaball_pixel_shader_core.sv @@
// ---------------------------------------------------------------------------
// metaball_pixel_shader_core
// Shades one pixel per transaction from two metaball fields and a ripple.
// ---------------------------------------------------------------------------
// Pipeline: ten register stages; out_valid is the valid bit of the last stage.
// Throughput: one pixel per cycle while out_ready is high; the two falloff dividers are 5-stage pipes.
// Each stage holds while the next one is full and stalled; bubbles collapse.
// Reset: valid bits clear, configuration registers return to their reset values; datapath registers are not reset.
module metaball_pixel_shader_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mbps_pkg::CoordW-1:0]   pixel_x,
  input  logic [mbps_pkg::CoordW-1:0]   pixel_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   pixel_color,
  output logic [7:0]                    coverage,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [23:0]                   cfg_data
);
  import mbps_pkg::*;

  // Configuration registers
  logic signed [PosW-1:0] blob_a_x, blob_a_y, blob_b_x, blob_b_y;
  logic [6:0]             blob_radius;
  logic [23:0]            accent_rgb;
  logic [8:0]             ring_amount;
  logic [5:0]             ring_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      blob_a_x    <= 9'sd64;
      blob_a_y    <= 9'sd64;
      blob_b_x    <= 9'sd64;
      blob_b_y    <= 9'sd64;
      blob_radius <= '0;
      accent_rgb  <= '0;
      ring_amount <= '0;
      ring_phase  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BLOB_A_X:    blob_a_x    <= cfg_data[8:0];
        REG_BLOB_A_Y:    blob_a_y    <= cfg_data[8:0];
        REG_BLOB_B_X:    blob_b_x    <= cfg_data[8:0];
        REG_BLOB_B_Y:    blob_b_y    <= cfg_data[8:0];
        REG_RADIUS:      blob_radius <= cfg_data[6:0];
        REG_ACCENT:      accent_rgb  <= cfg_data;
        REG_RING_AMOUNT: ring_amount <= cfg_data[8:0];
        REG_RING_PHASE:  ring_phase  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Radius clamp and derived terms
  logic [6:0]     rad;
  logic [R2W-1:0] r2;
  assign rad = (blob_radius < 7'd2) ? 7'd2 : blob_radius;
  assign r2  = R2W'(rad) * R2W'(rad);

  // Stall chain: a stage loads when it is empty or its successor loads
  logic [NumStages:1]   vld;
  logic [NumStages+1:1] en;

  always_comb begin
    en[NumStages+1] = out_ready;
    for (int i = NumStages; i >= 1; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= in_valid;
      for (int i = 2; i <= NumStages; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Stage 1: squared distances
  logic [D2W-1:0] d2a_1, d2b_1, d2c_1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d2a_1 <= sq_dist(pixel_x, pixel_y, blob_a_x, blob_a_y);
      d2b_1 <= sq_dist(pixel_x, pixel_y, blob_b_x, blob_b_y);
      d2c_1 <= sq_dist(pixel_x, pixel_y, PosW'(ImageWidth / 2), PosW'(ImageHeight / 2));
    end
  end

  // Stage 2: divisor setup and ripple band limits
  logic [DenW-1:0] dena_2, denb_2;
  logic [NumW-1:0] num_2;
  logic [D2W-1:0]  d2c_2;
  logic [15:0]     lo_2 [2];
  logic [15:0]     hi_2 [2];
  logic [16:0]     eprod_2 [2];

  function automatic logic [DenW-1:0] divisor(input logic [D2W-1:0] d2,
                                              input logic [R2W-1:0] rsq);
    logic [D2W-DistShift-1:0] q;
    logic [QW-1:0]            qc;
    q  = d2[D2W-1:DistShift];
    qc = (q >= (D2W-DistShift)'(FalloffEntries)) ? QW'(FalloffEntries - 1) : q[QW-1:0];
    return (DenW'(qc) << DistShift) + DenW'(rsq[R2W-1:2]) + DenW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (en[2]) begin
      logic [5:0] ph;
      logic [7:0] rr;
      dena_2 <= divisor(d2a_1, r2);
      denb_2 <= divisor(d2b_1, r2);
      num_2  <= {r2, 8'd0};
      d2c_2  <= d2c_1;
      for (int k = 0; k < 2; k++) begin
        ph         = ring_phase + 6'(k * 32);
        rr         = 8'(rad) + 8'd6 + 8'((12'(ph) * 12'(RingSpan)) >> 6);
        lo_2[k]    <= (16'(rr) - 16'd2) * (16'(rr) - 16'd2);
        hi_2[k]    <= (16'(rr) + 16'd2) * (16'(rr) + 16'd2);
        eprod_2[k] <= 17'(RingEnv[ph]) * 17'(ring_amount);
      end
    end
  end

  // Falloff dividers, stages 3 to 7
  logic [QuotW-1:0] qa_7, qb_7;

  mbps_div u_div_a (
    .clk  (clk),
    .en   (en[2+DivStages:3]),
    .num  (num_2),
    .den  (dena_2),
    .quot (qa_7)
  );

  mbps_div u_div_b (
    .clk  (clk),
    .en   (en[2+DivStages:3]),
    .num  (num_2),
    .den  (denb_2),
    .quot (qb_7)
  );

  // Stage 3: ripple hit test and strength, first band wins
  function automatic logic [7:0] ring_alpha(input logic [16:0] x);
    logic [8:0] q0;
    logic [9:0] r;
    logic [8:0] q;
    q0 = x[16:8];
    r  = 10'(x[7:0]) + 10'(q0);
    if (r >= 10'd510)      q = q0 + 9'd2;
    else if (r >= 10'd255) q = q0 + 9'd1;
    else                   q = q0;
    return (q > 9'(RingCap)) ? 8'(RingCap) : q[7:0];
  endfunction

  ring_t ring_q [3:2+DivStages];
  ring_t ring_3;

  always_comb begin
    logic hit0, hit1;
    hit0 = (d2c_2 >= D2W'(lo_2[0])) && (d2c_2 <= D2W'(hi_2[0]));
    hit1 = (d2c_2 >= D2W'(lo_2[1])) && (d2c_2 <= D2W'(hi_2[1]));
    ring_3.hit   = hit0 || hit1;
    ring_3.alpha = hit0 ? ring_alpha(eprod_2[0]) : ring_alpha(eprod_2[1]);
  end

  always_ff @(posedge clk) begin
    if (en[3]) ring_q[3] <= ring_3;
    for (int s = 4; s <= 2 + DivStages; s++) begin
      if (en[s]) ring_q[s] <= ring_q[s-1];
    end
  end

  // Stage 8: field sum, ramp and ripple select
  logic [7:0] alpha_8;
  logic       ring_sel_8;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      logic [QuotW:0] f;
      logic [7:0]     a;
      logic [13:0]    ramp;
      logic           use_ring;
      f    = (QuotW+1)'(qa_7) + (QuotW+1)'(qb_7);
      ramp = 14'(f - (QuotW+1)'(FieldLo)) * 14'd51;
      if (f <= (QuotW+1)'(FieldLo))      a = 8'd0;
      else if (f >= (QuotW+1)'(FieldHi)) a = 8'd255;
      else                               a = ramp[12:5];
      use_ring   = (a == 8'd0) && (ring_amount > 9'(RingMin)) && ring_q[2+DivStages].hit;
      alpha_8    <= use_ring ? ring_q[2+DivStages].alpha : a;
      ring_sel_8 <= use_ring;
    end
  end

  // Stage 9: per-channel blend
  logic [7:0] red_9, grn_9, blu_9, alpha_9;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      red_9   <= blend(PaperColor[23:16], accent_rgb[23:16], alpha_8);
      grn_9   <= blend(PaperColor[15:8],  accent_rgb[15:8],  alpha_8);
      blu_9   <= blend(PaperColor[7:0],   accent_rgb[7:0],   alpha_8);
      alpha_9 <= alpha_8;
    end
  end

  // Stage 10: RGB565 pack into the output register
  always_ff @(posedge clk) begin
    if (en[10]) begin
      pixel_color <= {red_9[7:3], grn_9[7:2], blu_9[7:3]};
      coverage    <= alpha_9;
    end
  end

  assign out_valid = vld[NumStages];

  // Checks
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&vld))
    else $error("input blocked while a stage is empty");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[1])
    else $error("accepted transaction did not reach stage 1");

  a_ring_cap: assert property (@(posedge clk) disable iff (rst)
    (vld[8] && ring_sel_8) |-> (alpha_8 <= 8'(RingCap)))
    else $error("ripple alpha above cap");

endmodule

@@ verif/tb_metaball_pixel_shader_core.sv @@
// ---------------------------------------------------------------------------
// tb_metaball_pixel_shader_core
// Streams pixels through the shader under several register settings and
// compares each shaded pixel against an in-bench prediction of the field,
// ripple and blend arithmetic.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_metaball_pixel_shader_core;
  import mbps_pkg::*;

  typedef struct packed {
    logic [15:0] color;
    logic [7:0]  alpha;
  } shade_t;

  // Register copy used by the predictor
  typedef struct {
    int          ax, ay, bx, by;
    int unsigned radius, accent, ripple_level, ring_ph;
  } shade_cfg_t;

  // Expected-shade store and checker
  class shade_scoreboard;
    shade_t pending[$];
    int     mismatches;
    int     checked;

    function void note_pixel(shade_t s);
      pending.push_back(s);
    endfunction

    function void check_pixel(logic [15:0] color, logic [7:0] alpha);
      shade_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result color=%h alpha=%0d", color, alpha);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.color !== color || e.alpha !== alpha) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: exp color=%h alpha=%0d, got color=%h alpha=%0d",
                   checked, e.color, e.alpha, color, alpha);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [6:0]  pixel_x;
  logic [6:0]  pixel_y;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] pixel_color;
  logic [7:0]  coverage;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  shade_scoreboard sb;
  shade_cfg_t      cfg;
  bit              sink_idle_on;
  bit              src_idle_on;
  int              hold_cycles;
  int              sink_gap;

  metaball_pixel_shader_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run-time limit
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned sqd(int x, int y, int cx, int cy);
    return (x - cx) * (x - cx) + (y - cy) * (y - cy);
  endfunction

  function automatic int unsigned field_of(int unsigned d2, int unsigned r2);
    int unsigned q;
    q = d2 >> 4;
    if (q >= FalloffEntries) q = FalloffEntries - 1;
    return ((r2 << 8) / ((q << 4) + r2 / 4 + 1)) & 16'hFFFF;
  endfunction

  function automatic logic [7:0] mix(int p, int c, int a);
    int prod, st;
    prod = (c - p) * a;
    st = prod >= 0 ? (prod >>> 8) : -((-prod + 255) >>> 8);
    return 8'(p + st);
  endfunction

  // Predicted shade of one pixel under the current registers
  function automatic shade_t shade_pixel(int x, int y);
    int unsigned r, r2, f, a, d2c, ph, rr, lo, hi, env, amt;
    logic [7:0]  cr, cg, cb;
    shade_t      s;
    r = cfg.radius < 2 ? 2 : cfg.radius;
    r2 = r * r;
    f = field_of(sqd(x, y, cfg.ax, cfg.ay), r2) + field_of(sqd(x, y, cfg.bx, cfg.by), r2);
    if (f <= FieldLo) a = 0;
    else if (f >= FieldHi) a = 255;
    else a = ((f - FieldLo) * 255) / (FieldHi - FieldLo);
    if (a == 0 && cfg.ripple_level > RingMin) begin
      d2c = sqd(x, y, ImageWidth / 2, ImageHeight / 2);
      for (int k = 0; k < 2; k++) begin
        ph = (cfg.ring_ph + k * 32) & 63;
        rr = r + 6 + (ph * RingSpan) / 64;
        lo = (rr - 2) * (rr - 2);
        hi = (rr + 2) * (rr + 2);
        if (d2c >= lo && d2c <= hi) begin
          env = ph < 12 ? (ph * 255) / 12 : ((63 - ph) * 255) / 51;
          amt = (env * cfg.ripple_level) / 255;
          a = amt > RingCap ? RingCap : amt;
          break;
        end
      end
    end
    cr = mix(PaperColor[23:16], cfg.accent[23:16], a);
    cg = mix(PaperColor[15:8], cfg.accent[15:8], a);
    cb = mix(PaperColor[7:0], cfg.accent[7:0], a);
    s.color = {cr[7:3], cg[7:2], cb[7:3]};
    s.alpha = 8'(a);
    return s;
  endfunction

  // One register write; the caller drops the write enable afterwards
  task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_BLOB_A_X:    cfg.ax = $signed(val[8:0]);
      REG_BLOB_A_Y:    cfg.ay = $signed(val[8:0]);
      REG_BLOB_B_X:    cfg.bx = $signed(val[8:0]);
      REG_BLOB_B_Y:    cfg.by = $signed(val[8:0]);
      REG_RADIUS:      cfg.radius = val[6:0];
      REG_ACCENT:      cfg.accent = val;
      REG_RING_AMOUNT: cfg.ripple_level = val[8:0];
      REG_RING_PHASE:  cfg.ring_ph = val[5:0];
      default: ;
    endcase
  endtask

  task automatic write_all(int ax, int ay, int bx, int by, int rad, int acc, int amt, int ph);
    write_reg(REG_BLOB_A_X, 24'(ax));
    write_reg(REG_BLOB_A_Y, 24'(ay));
    write_reg(REG_BLOB_B_X, 24'(bx));
    write_reg(REG_BLOB_B_Y, 24'(by));
    write_reg(REG_RADIUS, 24'(rad));
    write_reg(REG_ACCENT, 24'(acc));
    write_reg(REG_RING_AMOUNT, 24'(amt));
    write_reg(REG_RING_PHASE, 24'(ph));
    cfg_we <= 1'b0;
  endtask

  // Offer one pixel; holds valid until the transaction completes
  task automatic send_pixel(int x, int y);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_x  <= 7'(x);
    pixel_y  <= 7'(y);
    sb.note_pixel(shade_pixel(x, y));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Random phase: mostly pixels near blobs and the ripple bands
  task automatic random_pixels(int n);
    int cx, cy;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: begin cx = cfg.ax; cy = cfg.ay; end
        1: begin cx = cfg.bx; cy = cfg.by; end
        2: begin cx = 64; cy = 64; end
        default: begin cx = -1; cy = -1; end
      endcase
      if (cx < 0 || cy < 0 || cx > 127 || cy > 127)
        send_pixel($urandom_range(0, 127), $urandom_range(0, 127));
      else
        send_pixel((cx + $signed($urandom_range(0, 80)) - 40) & 127,
                   (cy + $signed($urandom_range(0, 80)) - 40) & 127);
    end
  endtask

  // Result side: random idle bursts, plus one long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_gap  <= 0;
    end else begin
      if (out_valid && out_ready) sb.check_pixel(pixel_color, coverage);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready   <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap  <= sink_gap - 1;
        out_ready <= 1'b0;
      end else if (sink_idle_on && out_ready && $urandom_range(0, 3) == 0) begin
        sink_gap  <= $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    sb = new();
    rst = 1'b1; in_valid = 1'b0; pixel_x = '0; pixel_y = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    sink_idle_on = 1'b1; src_idle_on = 1'b1; hold_cycles = 0;
    cfg = '{64, 64, 64, 64, 0, 0, 0, 0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers, then extremes and corners
    send_pixel(0, 0); send_pixel(127, 127); send_pixel(64, 64); send_pixel(70, 60);
    drain();
    write_all(-256, -256, 255, 255, 1, 24'h000000, 511, 0);
    send_pixel(0, 0); send_pixel(127, 0); send_pixel(0, 127); send_pixel(64, 56);
    send_pixel(64, 72); send_pixel(127, 127);
    drain();
    write_all(40, 40, 90, 80, 127, 24'hFFFFFF, 4, 63);
    send_pixel(40, 40); send_pixel(90, 80); send_pixel(0, 127);
    drain();
    write_all(30, 64, 98, 64, 12, 24'h123456, 5, 11);
    send_pixel(64, 64); send_pixel(30, 64); send_pixel(64, 82); send_pixel(85, 43);
    send_pixel(127, 64); send_pixel(64, 100);
    drain();
    write_all(20, 20, 110, 110, 6, 24'hAA55F0, 300, 40);

    // Long hold-off on the result side while pixels keep coming
    hold_cycles = 60;
    random_pixels(60);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_all($urandom_range(0, 511), $urandom_range(0, 511),
                $urandom_range(0, 140), $urandom_range(0, 140),
                $urandom_range(0, 30), $urandom_range(0, 24'hFFFFFF),
                $urandom_range(0, 511), $urandom_range(0, 63));
      random_pixels(280);
      drain();
    end

    // Last part: no idling at all
    sink_idle_on = 1'b0; src_idle_on = 1'b0;
    write_all(50, 70, 80, 60, 10, 24'h00FF00, 200, 20);
    random_pixels(200);
    drain();

    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
